>>> hdl/throttle_ramp_motor_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the throttle ramp motor controller
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef THROTTLE_RAMP_MOTOR_CONTROLLER_UNIT_ASSERT_SVH
`define THROTTLE_RAMP_MOTOR_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/trmc_pkg.sv
// ----------------------------------------------------------------------------
// trmc_pkg
// Shared widths of the throttle ramp motor controller.
// ----------------------------------------------------------------------------
package trmc_pkg;

  localparam int TIME_W  = 32;
  localparam int SPEED_W = 24;
  localparam int DUTY_W  = 8;
  localparam int CAP_W   = 7;

endpackage

>>> hdl/trmc_div.sv
// ----------------------------------------------------------------------------
// trmc_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trmc_div
  import trmc_pkg::*;
#(
  parameter int DVD_W = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0]  count;
  logic [DVD_W-1:0]  work;
  logic [TIME_W-1:0] dsr;
  logic [TIME_W-1:0] rem;
  logic [TIME_W:0]   shifted;
  logic              ge;
  logic [TIME_W:0]   sub;

  // A zero divisor makes every trial subtraction succeed, so the quotient
  // comes out as all ones, which is the saturated value.
  assign shifted = {rem, work[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign sub     = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == CNT_W'(1));
      if (start) begin
        count <= CNT_W'(DVD_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dsr  <= divisor;
      rem  <= '0;
    end else if (count != '0) begin
      work <= {work[DVD_W-2:0], ge};
      rem  <= ge ? sub[TIME_W-1:0] : shifted[TIME_W-1:0];
    end
  end

  assign quotient = work;

endmodule

>>> hdl/throttle_ramp_motor_controller_unit.sv
// An accepted request passes through the divider (calc state) and the emit
// state to the output register; the bit-serial divider takes one quotient bit per cycle.
// A new request is taken only in the idle state, after the last one is emitted.
// A finished result waits in the output register while the next request runs.
// Reset (rst, synchronous): configuration goes to its defaults, ramp, tick
// counter, speed and edge time to zero, gear latch to forward, unlock off.
// ----------------------------------------------------------------------------
// throttle_ramp_motor_controller_unit
// Pedal ramp limiter with hall speed measurement and forward/reverse duties.
// ----------------------------------------------------------------------------
`include "throttle_ramp_motor_controller_unit_assert.svh"

module throttle_ramp_motor_controller_unit
  import trmc_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [ADC_BITS-1:0] adc_sample,
  input  logic                forward_switch,
  input  logic                unlock_switch,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DUTY_W-1:0]   forward_duty,
  output logic [DUTY_W-1:0]   reverse_duty,
  output logic [SPEED_W-1:0]  speed_kmh_q8,
  output logic                gear_is_forward,
  output logic                full_speed_on
);

  localparam int NUM_W = ADC_BITS + 8;
  localparam int DVD_W = (NUM_W > SPEED_W) ? NUM_W : SPEED_W;
  localparam logic [DUTY_W-1:0] RAMP_FLOOR = DUTY_W'(10);

  typedef enum logic [2:0] {
    REG_UPPER   = 3'd0,
    REG_LOWER   = 3'd1,
    REG_INTERV  = 3'd2,
    REG_FWD_CAP = 3'd3,
    REG_REV_CAP = 3'd4,
    REG_TIMEOUT = 3'd5,
    REG_SPD_K   = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  // Configuration
  logic [9:0]         pedal_upper_limit;
  logic [9:0]         pedal_lower_limit;
  logic [7:0]         ramp_interval;
  logic [CAP_W-1:0]   safe_forward_cap;
  logic [CAP_W-1:0]   safe_reverse_cap;
  logic [15:0]        stop_timeout_ms;
  logic [SPEED_W-1:0] speed_constant;

  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_upper_limit <= 10'd810;
      pedal_lower_limit <= 10'd240;
      ramp_interval     <= 8'd60;
      safe_forward_cap  <= 7'd120;
      safe_reverse_cap  <= 7'd50;
      stop_timeout_ms   <= 16'd1000;
      speed_constant    <= 24'd337784;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER:   pedal_upper_limit <= cfg_data[9:0];
        REG_LOWER:   pedal_lower_limit <= cfg_data[9:0];
        REG_INTERV:  ramp_interval     <= cfg_data[7:0];
        REG_FWD_CAP: safe_forward_cap  <= cfg_data[CAP_W-1:0];
        REG_REV_CAP: safe_reverse_cap  <= cfg_data[CAP_W-1:0];
        REG_TIMEOUT: stop_timeout_ms   <= cfg_data[15:0];
        REG_SPD_K:   speed_constant    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block state
  state_t             state;
  logic [DUTY_W-1:0]  ramp_level;
  logic [7:0]         ramp_ticks;
  logic               latched_forward;
  logic               latched_unlock;
  logic [TIME_W-1:0]  last_edge_ms;
  logic [SPEED_W-1:0] speed_value;

  // Captured request
  logic              item_mode;
  logic [TIME_W-1:0] item_now;
  logic              item_fsw;
  logic              item_usw;
  logic              item_tmo;
  logic              item_hi;
  logic              item_lo;

  logic accept;
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Operand setup in the accept cycle
  logic [ADC_BITS-1:0] up_m;
  logic [ADC_BITS-1:0] lo_m;
  logic [ADC_BITS-1:0] span;
  logic [ADC_BITS-1:0] range;
  logic [NUM_W-1:0]    num;
  logic [TIME_W-1:0]   diff;
  logic [DVD_W-1:0]    div_dividend;
  logic [TIME_W-1:0]   div_divisor;
  logic                div_done;
  logic [DVD_W-1:0]    div_quotient;

  assign up_m  = ADC_BITS'(pedal_upper_limit);
  assign lo_m  = ADC_BITS'(pedal_lower_limit);
  assign span  = adc_sample - lo_m;
  assign range = up_m - lo_m;
  // Times 255 as times 256 minus one.
  assign num   = {span, 8'd0} - NUM_W'(span);
  assign diff  = now_ms - last_edge_ms;

  assign div_dividend = mode ? DVD_W'(speed_constant) : DVD_W'(num);
  assign div_divisor  = mode ? diff : TIME_W'(range);

  trmc_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Commit of a control tick
  logic [SPEED_W-1:0] speed_tick;
  logic [DUTY_W-1:0]  req_raw;
  logic [DUTY_W-1:0]  req;
  logic [7:0]         ticks_inc;
  logic [7:0]         ticks_next;
  logic [DUTY_W-1:0]  ramp_dec;
  logic [DUTY_W-1:0]  ramp_next;
  logic               latch_now;

  always_comb begin
    speed_tick = item_tmo ? '0 : speed_value;
    priority if (item_hi) begin
      req_raw = DUTY_W'(255);
    end else if (item_lo) begin
      req_raw = '0;
    end else begin
      req_raw = div_quotient[DUTY_W-1:0];
    end
    req       = latched_forward ? req_raw : (req_raw >> 1);
    ticks_inc = ramp_ticks + 8'd1;
    ramp_dec  = (ramp_level >= DUTY_W'(2)) ? ramp_level - DUTY_W'(2) : '0;
    ramp_next = ramp_level;
    ticks_next = ticks_inc;
    if (ticks_inc > ramp_interval) begin
      ticks_next = '0;
      if (req < ramp_level) begin
        ramp_next = (ramp_dec < RAMP_FLOOR) ? '0 : ramp_dec;
      end else if (req > ramp_level) begin
        ramp_next = ramp_level + DUTY_W'(1);
      end
    end
    latch_now = (ramp_next == '0) && (speed_tick == '0);
  end

  // Driven duty from the current state
  logic [CAP_W-1:0]  half_level;
  logic [CAP_W-1:0]  cap;
  logic [DUTY_W-1:0] drive;

  always_comb begin
    half_level = ramp_level[DUTY_W-1:1];
    cap        = latched_forward ? safe_forward_cap : safe_reverse_cap;
    if (latched_unlock) begin
      drive = ramp_level;
    end else begin
      drive = {1'b0, (half_level > cap) ? cap : half_level};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      ramp_level      <= '0;
      ramp_ticks      <= '0;
      latched_forward <= 1'b1;
      latched_unlock  <= 1'b0;
      last_edge_ms    <= '0;
      speed_value     <= '0;
    end else begin
      // In the emit state the output register is handled below.
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item_mode <= mode;
            item_now  <= now_ms;
            item_fsw  <= forward_switch;
            item_usw  <= unlock_switch;
            item_tmo  <= diff > TIME_W'(stop_timeout_ms);
            item_hi   <= adc_sample >= up_m;
            item_lo   <= adc_sample <= lo_m;
            state     <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (div_done) begin
            if (item_mode) begin
              last_edge_ms <= item_now;
              speed_value  <= SPEED_W'(div_quotient);
            end else begin
              speed_value <= speed_tick;
              ramp_level  <= ramp_next;
              ramp_ticks  <= ticks_next;
              if (latch_now) begin
                latched_forward <= item_fsw;
                latched_unlock  <= item_usw;
              end
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            forward_duty    <= latched_forward ? drive : '0;
            reverse_duty    <= latched_forward ? '0 : drive;
            speed_kmh_q8    <= speed_value;
            gear_is_forward <= latched_forward;
            full_speed_on   <= latched_unlock;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TRMC_ASSERT_SAME(a_done_in_calc, div_done, state == ST_CALC, "divider finished outside calc")
  `TRMC_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready stayed high after a request")
  `TRMC_ASSERT_SAME(a_fwd_gear_rev_zero, out_valid && gear_is_forward, reverse_duty == '0,
                    "reverse duty driven in forward gear")
  `TRMC_ASSERT_SAME(a_rev_gear_fwd_zero, out_valid && !gear_is_forward, forward_duty == '0,
                    "forward duty driven in reverse gear")

endmodule
